// File: rtl/lidar_frame_parser_core_assert.svh
// Assertion macros shared by the lidar frame parser RTL.
`ifndef LIDAR_FRAME_PARSER_CORE_ASSERT_SVH
`define LIDAR_FRAME_PARSER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define LFP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define LFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lfp_pkg.sv
// Types, constants and codes of the lidar frame parser.
`default_nettype none

package lfp_pkg;

   localparam int SAMPLES_PER_FRAME_DEFAULT = 22;
   localparam int SAMPLES_PER_FRAME_MAX     = 44;

   localparam logic [7:0] HDR_SYNC0 = 8'hAA;
   localparam logic [7:0] HDR_SYNC1 = 8'h00;
   localparam logic [7:0] HDR_MARK0 = 8'h61;
   localparam logic [7:0] HDR_MARK1 = 8'hAD;

   localparam logic [15:0] NEAR_LIMIT = 16'd2;
   localparam logic [15:0] NEAR_SUBST = 16'd250;

   localparam int SLOT_W      = 10;
   localparam int ANGLE_W     = 16;
   localparam int ANGLE_SECTOR = 2250;
   localparam int RECIP_SHIFT = 27;
   localparam int SECTOR_W    = 5;
   localparam int PROD_W      = 32;
   localparam longint RECIP_MULT_L = ((64'd1 << RECIP_SHIFT) + ANGLE_SECTOR - 1) / ANGLE_SECTOR;
   localparam logic [ANGLE_W-1:0] RECIP_MULT = ANGLE_W'(RECIP_MULT_L);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   localparam int HDR_POS_W = 4;
   localparam logic [HDR_POS_W-1:0] HDR_POS_SYNC1    = 4'd1;
   localparam logic [HDR_POS_W-1:0] HDR_POS_MARK0    = 4'd4;
   localparam logic [HDR_POS_W-1:0] HDR_POS_MARK1    = 4'd5;
   localparam logic [HDR_POS_W-1:0] HDR_POS_SPEED    = 4'd8;
   localparam logic [HDR_POS_W-1:0] HDR_POS_ANGLE_HI = 4'd11;
   localparam logic [HDR_POS_W-1:0] HDR_POS_ANGLE_LO = 4'd12;

   localparam int SAMP_POS_W = 3;
   localparam logic [SAMP_POS_W-1:0] SB_SIGNAL  = 3'd0;
   localparam logic [SAMP_POS_W-1:0] SB_DIST_HI = 3'd1;
   localparam logic [SAMP_POS_W-1:0] SB_DIST_LO = 3'd2;
   localparam logic [SAMP_POS_W-1:0] SB_LAST    = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_SAMPLE,
      ST_TRAIL_FIRST,
      ST_TRAIL_LAST
   } parse_state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot_index;
      logic [15:0]       range_value;
      logic [7:0]        strength;
      logic [7:0]        spin_speed;
      logic [15:0]       frames_seen;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: rtl/lfp_stream_if.sv
// Valid/ready stream interface carrying one payload per transfer.
`default_nettype none

interface lfp_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/lidar_frame_parser_core.sv
// Lidar frame parser: one link byte per transfer in, sample and frame results out.
// A result is registered in the output buffer (head entry, or skid entry while the head waits) before it shows on rsp.
// Throughput: one byte per cycle; a two-entry output buffer lets bytes keep
// transferring while a result waits, and req stalls only when both entries are full.
// Reset: synchronous; parser returns to idle hunting for the sync byte, the frame
// counter clears and both output entries empty.
`default_nettype none

module lidar_frame_parser_core
   import lfp_pkg::*;
#(
   parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lfp_stream_if.sink   req,
   lfp_stream_if.source rsp
);

   `include "lidar_frame_parser_core_assert.svh"

   localparam int NUM_W = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
   localparam int BASE_W = SECTOR_W + $clog2(SAMPLES_PER_FRAME + 1) + 1;
   localparam int SUM_W = (BASE_W > SLOT_W) ? BASE_W : SLOT_W;
   localparam logic [NUM_W-1:0] NUM_LAST = NUM_W'(SAMPLES_PER_FRAME - 1);

   parse_state_type          state_ff, state_in;
   logic [HDR_POS_W-1:0]     hdr_pos_ff, hdr_pos_in;
   logic [SAMP_POS_W-1:0]    samp_pos_ff, samp_pos_in;
   logic [NUM_W-1:0]         samp_num_ff, samp_num_in;
   logic [15:0]              frame_counter_ff, frame_counter_in;

   logic [ANGLE_W-1:0]       start_angle_ff;
   logic [SECTOR_W-1:0]      sector_ff, sector_in;
   logic [7:0]               dist_high_ff;
   logic [7:0]               strength_ff;
   logic [7:0]               speed_ff;

   logic                     head_valid_ff, skid_valid_ff;
   rsp_payload_type          head_ff, skid_ff;

   logic                     accept;
   logic [7:0]               rx_byte;
   logic                     cap_speed, cap_angle_hi, cap_angle_lo;
   logic                     cap_strength, cap_dist_hi;
   logic                     emit_sample, emit_frame, push, pop;
   logic [PROD_W-1:0]        sector_prod;
   logic [SUM_W-1:0]         slot_sum;
   logic [15:0]              range_raw;
   rsp_payload_type          new_rsp;

   assign rx_byte   = req.payload.rx_byte;
   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;

   // next state
   always_comb begin
      state_in    = state_ff;
      hdr_pos_in  = hdr_pos_ff;
      samp_pos_in = samp_pos_ff;
      samp_num_in = samp_num_ff;
      if (accept) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rx_byte == HDR_SYNC0) begin
                  state_in   = ST_HEADER;
                  hdr_pos_in = HDR_POS_SYNC1;
               end
            end
            ST_HEADER: begin
               hdr_pos_in = hdr_pos_ff + HDR_POS_W'(1);
               case (hdr_pos_ff)
                  HDR_POS_SYNC1: if (rx_byte != HDR_SYNC1) state_in = ST_IDLE;
                  HDR_POS_MARK0: if (rx_byte != HDR_MARK0) state_in = ST_IDLE;
                  HDR_POS_MARK1: if (rx_byte != HDR_MARK1) state_in = ST_IDLE;
                  HDR_POS_ANGLE_LO: begin
                     state_in    = ST_SAMPLE;
                     samp_pos_in = SB_SIGNAL;
                     samp_num_in = '0;
                  end
                  default: ;
               endcase
            end
            ST_SAMPLE: begin
               if (samp_pos_ff == SB_LAST) begin
                  samp_pos_in = SB_SIGNAL;
                  if (samp_num_ff == NUM_LAST) begin
                     state_in = ST_TRAIL_FIRST;
                  end else begin
                     samp_num_in = samp_num_ff + NUM_W'(1);
                  end
               end else begin
                  samp_pos_in = samp_pos_ff + SAMP_POS_W'(1);
               end
            end
            ST_TRAIL_FIRST: state_in = ST_TRAIL_LAST;
            ST_TRAIL_LAST:  state_in = ST_IDLE;
            default:        state_in = ST_IDLE;
         endcase
      end
   end

   // outputs
   always_comb begin
      cap_speed    = 1'b0;
      cap_angle_hi = 1'b0;
      cap_angle_lo = 1'b0;
      cap_strength = 1'b0;
      cap_dist_hi  = 1'b0;
      emit_sample  = 1'b0;
      emit_frame   = 1'b0;
      if (accept) begin
         unique case (state_ff)
            ST_HEADER: begin
               cap_speed    = (hdr_pos_ff == HDR_POS_SPEED);
               cap_angle_hi = (hdr_pos_ff == HDR_POS_ANGLE_HI);
               cap_angle_lo = (hdr_pos_ff == HDR_POS_ANGLE_LO);
            end
            ST_SAMPLE: begin
               cap_strength = (samp_pos_ff == SB_SIGNAL);
               cap_dist_hi  = (samp_pos_ff == SB_DIST_HI);
               emit_sample  = (samp_pos_ff == SB_DIST_LO);
            end
            ST_TRAIL_LAST: emit_frame = 1'b1;
            default: ;
         endcase
      end
   end

   assign sector_prod = PROD_W'(start_angle_ff) * PROD_W'(RECIP_MULT);
   assign sector_in   = sector_prod[RECIP_SHIFT +: SECTOR_W];

   assign slot_sum  = SUM_W'(sector_ff) * SUM_W'(SAMPLES_PER_FRAME) + SUM_W'(samp_num_ff);
   assign range_raw = {dist_high_ff, rx_byte};
   assign frame_counter_in = emit_frame ? frame_counter_ff + 16'd1 : frame_counter_ff;

   always_comb begin
      new_rsp = '0;
      if (emit_frame) begin
         new_rsp.kind        = KIND_FRAME;
         new_rsp.spin_speed  = speed_ff;
         new_rsp.frames_seen = frame_counter_in;
      end else begin
         new_rsp.kind        = KIND_SAMPLE;
         new_rsp.slot_index  = slot_sum[SLOT_W-1:0];
         new_rsp.range_value = (range_raw > NEAR_LIMIT) ? range_raw : NEAR_SUBST;
         new_rsp.strength    = strength_ff;
      end
   end

   assign push = emit_sample || emit_frame;
   assign pop  = head_valid_ff && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         hdr_pos_ff       <= '0;
         samp_pos_ff      <= '0;
         samp_num_ff      <= '0;
         frame_counter_ff <= '0;
         head_valid_ff    <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         hdr_pos_ff       <= hdr_pos_in;
         samp_pos_ff      <= samp_pos_in;
         samp_num_ff      <= samp_num_in;
         frame_counter_ff <= frame_counter_in;
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (!head_valid_ff || pop) begin
               head_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            head_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      if (cap_speed)    speed_ff              <= rx_byte;
      if (cap_angle_hi) start_angle_ff[15:8]  <= rx_byte;
      if (cap_angle_lo) start_angle_ff[7:0]   <= rx_byte;
      if (cap_strength) strength_ff           <= rx_byte;
      if (cap_dist_hi)  dist_high_ff          <= rx_byte;
      if (skid_valid_ff) begin
         if (pop) head_ff <= skid_ff;
      end else if (push) begin
         if (!head_valid_ff || pop) begin
            head_ff <= new_rsp;
         end else begin
            skid_ff <= new_rsp;
         end
      end
   end

   assign rsp.valid   = head_valid_ff;
   assign rsp.payload = head_ff;

   `LFP_ASSERT_IMPLY(a_skid_needs_head, skid_valid_ff, head_valid_ff, "skid full, head empty")
   `LFP_ASSERT_NEXT(a_frame_to_idle, accept && (state_ff == ST_TRAIL_LAST),
      state_ff == ST_IDLE, "frame end did not return to idle")
   `LFP_ASSERT(a_samp_pos_range, samp_pos_ff <= SB_LAST, "sample byte position out of range")

endmodule

`default_nettype wire

// File: sim/lidar_frame_parser_core_tb.sv
// Self-checking testbench of the lidar frame parser: byte stream in, sample and frame results out.
`default_nettype none

module lidar_frame_parser_core_tb
   import lfp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES      = SAMPLES_PER_FRAME_DEFAULT;
   localparam int SAMPLE_BASE  = 13;
   localparam int SAMPLE_BYTES = 6;
   localparam int TRAIL_FIRST  = SAMPLE_BASE + SAMPLE_BYTES * SAMPLES;
   localparam int FRAME_BYTES  = TRAIL_FIRST + 2;
   localparam int ITEM_TARGET  = 1800;
   localparam int STALL_LIMIT  = 2000;
   localparam int IDLE_PCT     = 25;

   class lidar_scoreboard;
      int unsigned     samples;
      int unsigned     phase;
      logic [15:0]     start_angle;
      logic [7:0]      dist_hi;
      logic [7:0]      signal_hold;
      logic [7:0]      speed_hold;
      logic [15:0]     frame_count;
      rsp_payload_type expected_q[$];
      int              errors;

      function new(int unsigned n);
         samples     = n;
         phase       = 0;
         start_angle = '0;
         dist_hi     = '0;
         signal_hold = '0;
         speed_hold  = '0;
         frame_count = '0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string msg);
         $display("%0t ERROR %s", $realtime, msg);
         errors++;
      endtask

      // Advance the parser by one link byte and queue the result it causes.
      function void note_byte(logic [7:0] b);
         rsp_payload_type r;
         bit              emit;
         int unsigned     off;
         logic [15:0]     range_raw;
         r    = '0;
         emit = 0;
         case (phase)
            0: phase = (b == HDR_SYNC0) ? 1 : 0;
            HDR_POS_SYNC1: phase = (b == HDR_SYNC1) ? 2 : 0;
            HDR_POS_MARK0: phase = (b == HDR_MARK0) ? 5 : 0;
            HDR_POS_MARK1: phase = (b == HDR_MARK1) ? 6 : 0;
            HDR_POS_SPEED: begin
               speed_hold = b;
               phase++;
            end
            HDR_POS_ANGLE_HI: begin
               start_angle = {b, 8'h00};
               phase++;
            end
            HDR_POS_ANGLE_LO: begin
               start_angle[7:0] = b;
               phase = SAMPLE_BASE;
            end
            2, 3, 6, 7, 9, 10: phase++;
            default: begin
               if (phase > TRAIL_FIRST) begin
                  frame_count   = frame_count + 16'd1;
                  r.kind        = KIND_FRAME;
                  r.spin_speed  = speed_hold;
                  r.frames_seen = frame_count;
                  phase         = 0;
                  emit          = 1;
               end else if (phase == TRAIL_FIRST) begin
                  phase++;
               end else begin
                  off = phase - SAMPLE_BASE;
                  phase++;
                  case (off % SAMPLE_BYTES)
                     SB_SIGNAL:  signal_hold = b;
                     SB_DIST_HI: dist_hi = b;
                     SB_DIST_LO: begin
                        range_raw     = {dist_hi, b};
                        r.kind        = KIND_SAMPLE;
                        r.slot_index  = SLOT_W'((start_angle / ANGLE_SECTOR) * samples
                                                + off / SAMPLE_BYTES);
                        r.range_value = (range_raw > NEAR_LIMIT) ? range_raw : NEAR_SUBST;
                        r.strength    = signal_hold;
                        emit          = 1;
                     end
                     default: ;
                  endcase
               end
            end
         endcase
         if (emit) expected_q.push_back(r);
      endfunction

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
         end else begin
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind %h, want %h", got.kind, want.kind));
            if (got.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index %0d, want %0d",
                                         got.slot_index, want.slot_index));
            if (got.range_value !== want.range_value)
               report_mismatch($sformatf("range_value %0d, want %0d",
                                         got.range_value, want.range_value));
            if (got.strength !== want.strength)
               report_mismatch($sformatf("strength %h, want %h", got.strength, want.strength));
            if (got.spin_speed !== want.spin_speed)
               report_mismatch($sformatf("spin_speed %h, want %h",
                                         got.spin_speed, want.spin_speed));
            if (got.frames_seen !== want.frames_seen)
               report_mismatch($sformatf("frames_seen %0d, want %0d",
                                         got.frames_seen, want.frames_seen));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   quiet_cycles;
   int   counted_bytes;
   logic [7:0] link_bytes[$];
   lidar_scoreboard sb;

   lfp_stream_if #(.payload_type(req_payload_type)) req_if ();
   lfp_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   lidar_frame_parser_core #(
      .SAMPLES_PER_FRAME(SAMPLES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      calm  = 1'b0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      quiet_cycles   = 0;
      counted_bytes  = 0;
      sb = new(SAMPLES);
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_if.valid && req_if.ready) sb.note_byte(req_if.payload.rx_byte);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("FAIL lidar_frame_parser_core");
            $finish;
         end
      end
   end

   function logic [15:0] pick_range();
      case ($urandom_range(0, 9))
         0: return 16'($urandom_range(0, 3));
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function logic [15:0] pick_angle();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(ANGLE_SECTOR - 1);
         3: return 16'(ANGLE_SECTOR);
         4: return 16'($urandom_range(63000, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   function void build_frame(logic [15:0] angle, logic [7:0] speed, bit edge_values);
      logic [15:0] range_pick;
      logic [15:0] edge_dist[7];
      edge_dist = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'h0100, 16'h00FF};
      link_bytes.push_back(HDR_SYNC0);
      link_bytes.push_back(HDR_SYNC1);
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(HDR_MARK0);
      link_bytes.push_back(HDR_MARK1);
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(speed);
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(angle[15:8]);
      link_bytes.push_back(angle[7:0]);
      for (int s = 0; s < SAMPLES; s++) begin
         range_pick = (edge_values && s < 7) ? edge_dist[s] : pick_range();
         if (edge_values) link_bytes.push_back(s[0] ? 8'hFF : 8'h00);
         else link_bytes.push_back(8'($urandom));
         link_bytes.push_back(range_pick[15:8]);
         link_bytes.push_back(range_pick[7:0]);
         for (int k = 0; k < 3; k++) link_bytes.push_back(8'($urandom));
      end
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(8'($urandom));
      counted_bytes += FRAME_BYTES;
   endfunction

   // Header that breaks off at one of the checked positions.
   function void build_broken();
      int unsigned where;
      logic [7:0]  b;
      where = $urandom_range(0, 2);
      link_bytes.push_back(HDR_SYNC0);
      if (where == 0) begin
         do b = ($urandom_range(0, 3) == 0) ? HDR_SYNC0 : 8'($urandom);
         while (b == HDR_SYNC1);
         link_bytes.push_back(b);
         counted_bytes += 2;
         return;
      end
      link_bytes.push_back(HDR_SYNC1);
      link_bytes.push_back(8'($urandom));
      link_bytes.push_back(8'($urandom));
      if (where == 1) begin
         do b = 8'($urandom); while (b == HDR_MARK0);
         link_bytes.push_back(b);
         counted_bytes += 5;
         return;
      end
      link_bytes.push_back(HDR_MARK0);
      do b = 8'($urandom); while (b == HDR_MARK1);
      link_bytes.push_back(b);
      counted_bytes += 6;
   endfunction

   function void build_random(int target);
      int unsigned pick;
      while (counted_bytes < target) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            build_frame(pick_angle(), 8'($urandom), 1'b0);
         end else if (pick == 7) begin
            build_broken();
         end else begin
            repeat ($urandom_range(1, 6)) link_bytes.push_back(8'($urandom));
         end
      end
   endfunction

   task send_byte(logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.payload.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task send_all();
      foreach (link_bytes[i]) send_byte(link_bytes[i]);
      req_if.valid <= 1'b0;
      link_bytes.delete();
      @(posedge clock);
   endtask

   task drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle noise, sync byte rejected at position one, mark misses at four and five
      link_bytes = '{8'h00, 8'hFF, 8'h55,
                     8'hAA, 8'hAA, 8'h00,
                     8'hAA, 8'h00, 8'h12, 8'h34, 8'h62,
                     8'hAA, 8'h00, 8'h56, 8'h78, 8'h61, 8'hAC};
      build_frame(16'hFFFF, 8'hFF, 1'b1);
      build_frame(16'h0000, 8'h00, 1'b1);
      send_all();
      drain();

      build_random(ITEM_TARGET / 2);
      send_all();
      drain();

      calm = 1'b1;
      build_random(ITEM_TARGET * 3 / 4);
      send_all();
      calm = 1'b0;

      build_random(ITEM_TARGET);
      send_all();
      drain();
      repeat (8) @(posedge clock);

      if (sb.errors == 0) begin
         $display("PASS lidar_frame_parser_core");
      end else begin
         $display("FAIL lidar_frame_parser_core");
      end
      $finish;
   end

endmodule

`default_nettype wire
